### hw/rtl/hkg_pkg.sv
// Shared constants, types and helpers for the held-key glow envelope.
package hkg_pkg;

  localparam int MAX_PIXELS = 128;
  localparam int PIX_AW     = $clog2(MAX_PIXELS);
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

  localparam int LEVEL_W    = 8;
  localparam int ENTRY_W    = LEVEL_W + 1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

  localparam int TIME_W     = 32;
  localparam int REL_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam int DIV_STEPS  = TIME_W;
  localparam int DIV_CW     = $clog2(DIV_STEPS);

  localparam logic [REL_W-1:0]   RELEASE_RST = 16'd500;
  localparam logic [LEVEL_W-1:0] BASE_RST    = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_FADE_MS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_BRIGHT = 1'd1;

  typedef enum logic [1:0] {
    ACT_KEY  = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [LEVEL_W-1:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return sum[15:8];
  endfunction

endpackage

### hw/rtl/hkg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
module hkg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/hkg_div.sv
// Radix-2 restoring divider: 32-bit dividend by 16-bit divisor, one bit a cycle.
module hkg_div
  import hkg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [REL_W-1:0]  divisor,
  output logic              done,
  output logic [TIME_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] step_r, step_nxt;
  logic [REL_W:0]    rem_r, rem_nxt;
  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [REL_W-1:0]  dvs_r, dvs_nxt;

  always_comb begin
    logic [REL_W:0] rem_sh;
    logic           fits;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r[REL_W-1:0], quo_r[TIME_W-1]};
    fits     = rem_sh >= {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // shift one dividend bit in, one quotient bit out
      rem_nxt  = fits ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_nxt  = {quo_r[TIME_W-2:0], fits};
      step_nxt = step_r + DIV_CW'(1);
      if (step_r == DIV_CW'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hw/rtl/held_key_glow_envelope_core.sv
// Top level of the held-key glow envelope: command FSM, level memory and fade tracking.
//
// Per-pixel glow envelope for key-hold lighting. Each command beat (start high while
// busy is low) carries a key event, a frame tick or a pixel read, and yields exactly
// one result beat on out_valid, one cycle wide; the receiver cannot stall it, so
// sample the outputs whenever out_valid is high. Commands are served one at a time.
// An out-of-range key event or pixel read, a frame tick whose time did not advance and an
// unknown action finish without busy rising: the result shows in the cycle after the command.
// An in-range key event reads the level memory and writes the entry back; a pixel read
// goes through level memory read, base times level multiply, divide by 255. A frame
// tick whose time advanced runs the bit-serial divider that turns the elapsed time into
// a drop, then one sweep over the level memory at one entry per cycle; with a zero
// fade time the divider is skipped. The held flag and level share one memory; per-entry
// valid bits stand for the cleared state after reset, so no clearing pass is needed.
// animating comes from a running count of fading pixels.
// Write configuration only while busy is low and no result is pending.
module held_key_glow_envelope_core
  import hkg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_action,
  input  logic [15:0]           in_pixel,
  input  logic                  in_pressed,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  output logic                  out_lit,
  output logic [LEVEL_W-1:0]    out_level,
  output logic [LEVEL_W-1:0]    out_brightness,
  output logic                  out_animating,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY_WB,
    S_RD_MUL,
    S_RD_OUT,
    S_TICK_PREP,
    S_DIV_WAIT,
    S_SWEEP
  } state_t;

  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_lit_r, out_lit_nxt;
  logic [LEVEL_W-1:0]    out_level_r, out_level_nxt;
  logic [LEVEL_W-1:0]    out_bright_r, out_bright_nxt;
  logic                  out_anim_r, out_anim_nxt;

  logic [MAX_PIXELS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]      fade_cnt_r, fade_cnt_nxt;
  logic [CNT_W-1:0]      sw_cnt_r, sw_cnt_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [TIME_W-1:0]     last_time_r, last_time_nxt;
  logic [REL_W-1:0]      release_r, release_nxt;
  logic [LEVEL_W-1:0]    base_r, base_nxt;

  logic [TIME_W-1:0]     elapsed_r, elapsed_nxt;
  logic [LEVEL_W-1:0]    drop_r, drop_nxt;
  logic [15:0]           prod_r, prod_nxt;
  logic [LEVEL_W-1:0]    lvl_r, lvl_nxt;
  logic                  press_r, press_nxt;
  logic [PIX_AW-1:0]     rd_addr_q_r;

  logic [PIX_AW-1:0]     ram_raddr;
  logic                  ram_we;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;

  logic                  div_start;
  logic                  div_done;
  logic [TIME_W-1:0]     div_dividend;
  logic [TIME_W-1:0]     div_quo;

  logic                  accept;
  logic                  pix_in_range;
  logic                  ent_vld;
  logic                  ent_held;
  logic [LEVEL_W-1:0]    ent_lvl;
  logic                  old_fade;

  hkg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PIXELS)
  ) u_level_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr_q_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hkg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (release_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign busy         = state_r != S_IDLE;
  assign accept       = start && !busy;
  assign pix_in_range = in_pixel < 16'(MAX_PIXELS);

  // An entry never written since reset reads as dark and released.
  assign ent_vld  = valid_r[rd_addr_q_r];
  assign ent_held = ent_vld & ram_rdata[ENTRY_W-1];
  assign ent_lvl  = ent_vld ? ram_rdata[LEVEL_W-1:0] : '0;
  assign old_fade = !ent_held && (ent_lvl != '0);

  // elapsed * 255 modulo 2^32, as a shift and a subtract
  assign div_dividend = {elapsed_r[TIME_W-9:0], 8'd0} - elapsed_r;

  // Sweep reads the next entry while the one before is written back.
  assign ram_raddr = (state_r == S_SWEEP) ? sw_cnt_r[PIX_AW-1:0] : in_pixel[PIX_AW-1:0];

  always_comb begin
    logic [LEVEL_W-1:0] new_lvl;
    logic               new_held;
    logic               new_fade;
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    out_lit_nxt    = out_lit_r;
    out_level_nxt  = out_level_r;
    out_bright_nxt = out_bright_r;
    out_anim_nxt   = out_anim_r;
    valid_nxt      = valid_r;
    fade_cnt_nxt   = fade_cnt_r;
    sw_cnt_nxt     = sw_cnt_r;
    rd_pend_nxt    = rd_pend_r;
    last_time_nxt  = last_time_r;
    release_nxt    = release_r;
    base_nxt       = base_r;
    elapsed_nxt    = elapsed_r;
    drop_nxt       = drop_r;
    prod_nxt       = prod_r;
    lvl_nxt        = lvl_r;
    press_nxt      = press_r;
    ram_we         = 1'b0;
    ram_wdata      = '0;
    div_start      = 1'b0;
    new_lvl        = '0;
    new_held       = 1'b0;
    new_fade       = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FADE_MS:     release_nxt = cfg_wdata[REL_W-1:0];
        CFG_BASE_BRIGHT: base_nxt    = cfg_wdata[LEVEL_W-1:0];
        default:         ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // default result for beats that finish at once
          out_lit_nxt    = 1'b0;
          out_level_nxt  = '0;
          out_bright_nxt = '0;
          out_anim_nxt   = fade_cnt_r != '0;
          unique case (action_t'(in_action))
            ACT_KEY: begin
              press_nxt = in_pressed;
              if (pix_in_range) begin
                state_nxt = S_KEY_WB;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ACT_TICK: begin
              last_time_nxt = in_now_ms;
              elapsed_nxt   = in_now_ms - last_time_r;
              if (in_now_ms > last_time_r) begin
                state_nxt = S_TICK_PREP;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ACT_READ: begin
              if (pix_in_range) begin
                state_nxt = S_RD_MUL;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ACT_NONE: begin
              out_valid_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_KEY_WB: begin
        new_held = press_r;
        new_lvl  = press_r ? LEVEL_MAX : ent_lvl;
        new_fade = !new_held && (new_lvl != '0);
        ram_we   = 1'b1;
        ram_wdata = {new_held, new_lvl};
        valid_nxt[rd_addr_q_r] = 1'b1;
        fade_cnt_nxt  = fade_cnt_r + CNT_W'(new_fade) - CNT_W'(old_fade);
        out_anim_nxt  = fade_cnt_nxt != '0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_RD_MUL: begin
        lvl_nxt   = ent_lvl;
        prod_nxt  = base_r * ent_lvl;
        state_nxt = S_RD_OUT;
      end

      S_RD_OUT: begin
        out_lit_nxt    = lvl_r != '0;
        out_level_nxt  = lvl_r;
        out_bright_nxt = div255(prod_r);
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_TICK_PREP: begin
        sw_cnt_nxt  = '0;
        rd_pend_nxt = 1'b0;
        if (release_r == '0) begin
          drop_nxt  = LEVEL_MAX;
          state_nxt = S_SWEEP;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV_WAIT;
        end
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          // any drop of 255 or more empties an unheld pixel
          drop_nxt  = (div_quo[TIME_W-1:LEVEL_W] != '0) ? LEVEL_MAX : div_quo[LEVEL_W-1:0];
          state_nxt = S_SWEEP;
        end
      end

      S_SWEEP: begin
        if (sw_cnt_r < CNT_W'(MAX_PIXELS)) begin
          sw_cnt_nxt  = sw_cnt_r + CNT_W'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
        end
        if (rd_pend_r) begin
          // pin held pixels, decay the rest and saturate at dark
          new_held  = ent_held;
          new_lvl   = ent_held ? LEVEL_MAX
                               : ((ent_lvl > drop_r) ? ent_lvl - drop_r : '0);
          new_fade  = !new_held && (new_lvl != '0);
          ram_we    = 1'b1;
          ram_wdata = {new_held, new_lvl};
          valid_nxt[rd_addr_q_r] = 1'b1;
          fade_cnt_nxt = fade_cnt_r + CNT_W'(new_fade) - CNT_W'(old_fade);
          if (sw_cnt_r == CNT_W'(MAX_PIXELS)) begin
            out_anim_nxt  = fade_cnt_nxt != '0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_lit_r    <= out_lit_nxt;
    out_level_r  <= out_level_nxt;
    out_bright_r <= out_bright_nxt;
    out_anim_r   <= out_anim_nxt;
    elapsed_r    <= elapsed_nxt;
    drop_r       <= drop_nxt;
    prod_r       <= prod_nxt;
    lvl_r        <= lvl_nxt;
    press_r      <= press_nxt;
    rd_addr_q_r  <= ram_raddr;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      fade_cnt_r  <= '0;
      sw_cnt_r    <= '0;
      rd_pend_r   <= 1'b0;
      last_time_r <= '0;
      release_r   <= RELEASE_RST;
      base_r      <= BASE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      fade_cnt_r  <= fade_cnt_nxt;
      sw_cnt_r    <= sw_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      last_time_r <= last_time_nxt;
      release_r   <= release_nxt;
      base_r      <= base_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lit        = out_lit_r;
  assign out_level      = out_level_r;
  assign out_brightness = out_bright_r;
  assign out_animating  = out_anim_r;

  // Results only show once the FSM is back to idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // Every accepted command either occupies the FSM or answers next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted command dropped");

  // The fading count can never exceed the pixel count.
  a_fade_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fade_cnt_r <= CNT_W'(MAX_PIXELS))
    else $error("fade count out of range");

  // A lit result has a nonzero level; an unlit one carries no brightness.
  a_lit_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lit == (out_level != '0)) && (out_lit || out_brightness == '0))
    else $error("lit flag disagrees with level");

  // Scaling by level / 255 never brightens beyond the level itself.
  a_bright_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_brightness <= out_level)
    else $error("brightness above level");

endmodule

### dv/tb_held_key_glow_envelope_core.sv
// Self-checking testbench for the held-key glow envelope core.
`timescale 1ns / 100ps

module tb_held_key_glow_envelope_core
  import hkg_pkg::*;
();

  // Run length: the slowest legal run is roughly 620 beats, each a full tick
  // sweep plus the longest gap, about 2.1 ms. The watchdog allows several times that.
  localparam int  SETTLE_CYC  = 4;
  localparam int  TAIL_CYC    = 2 * (MAX_PIXELS + 40);
  localparam int  PHASE_BEATS = 85;
  localparam time WATCHDOG_NS = 15_000_000;

  typedef enum logic {BEAT_CMD, BEAT_CFG} beat_kind_t;

  // One entry of the stimulus queue: either a command beat or a register write.
  typedef struct {
    beat_kind_t             kind;
    action_t                action;
    logic [15:0]            pixel;
    logic                   pressed;
    logic [TIME_W-1:0]      now_ms;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int unsigned            gap;
  } cmd_beat_t;

  typedef struct {
    logic               lit;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] brightness;
    logic               animating;
  } glow_res_t;

  // DUT connections; every input holds a known value from time zero.
  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  start          = 1'b0;
  logic                  busy;
  logic [1:0]            in_action      = '0;
  logic [15:0]           in_pixel       = '0;
  logic                  in_pressed     = 1'b0;
  logic [TIME_W-1:0]     in_now_ms      = '0;
  logic                  out_valid;
  logic                  out_lit;
  logic [LEVEL_W-1:0]    out_level;
  logic [LEVEL_W-1:0]    out_brightness;
  logic                  out_animating;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;

  held_key_glow_envelope_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_pixel       (in_pixel),
    .in_pressed     (in_pressed),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_lit        (out_lit),
    .out_level      (out_level),
    .out_brightness (out_brightness),
    .out_animating  (out_animating),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Envelope predictor: private copy of the pixel store, the tick clock and
  // the two registers. Advanced once per accepted command beat, in order.
  // ---------------------------------------------------------------------------
  logic               held_flag   [MAX_PIXELS];
  logic [LEVEL_W-1:0] glow_level  [MAX_PIXELS];
  logic [TIME_W-1:0]  last_tick_ms;
  logic [REL_W-1:0]   fade_ms;
  logic [LEVEL_W-1:0] base_bright;

  cmd_beat_t   cmd_q[$];          // beats not yet driven
  glow_res_t   glow_result_q[$];  // results predicted but not yet seen
  cmd_beat_t   cur_cmd;           // beat currently offered on start
  int unsigned gap_left      = 0;
  int unsigned settle_cnt    = 0;
  int unsigned beats_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned act_count[4]  = '{default: 0};
  int unsigned cfg_writes    = 0;
  int unsigned n_errors      = 0;
  int unsigned n_checked     = 0;
  int unsigned n_lit         = 0;
  int unsigned n_fading      = 0;
  logic [TIME_W-1:0] sim_ms  = '0;  // running time used to build ticks
  bit          bursty        = 1'b1;

  function automatic glow_res_t glow_step(input cmd_beat_t c);
    glow_res_t         r;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] scaled;
    logic [TIME_W-1:0] drop;
    logic [15:0]       prod;
    logic [PIX_AW-1:0] px;
    r  = '{lit: 1'b0, level: '0, brightness: '0, animating: 1'b0};
    px = c.pixel[PIX_AW-1:0];
    case (c.action)
      ACT_KEY: begin
        // Drop out-of-range events; a press relights to full.
        if (c.pixel < 16'(MAX_PIXELS)) begin
          held_flag[px] = c.pressed;
          if (c.pressed)
            glow_level[px] = LEVEL_MAX;
        end
      end
      ACT_TICK: begin
        elapsed = (c.now_ms > last_tick_ms) ? c.now_ms - last_tick_ms : '0;
        last_tick_ms = c.now_ms;
        if (elapsed != '0) begin
          scaled = elapsed * 32'd255;  // wraps at 32 bits on purpose
          drop = (fade_ms == '0) ? 32'd255 : scaled / {16'd0, fade_ms};
          for (int i = 0; i < MAX_PIXELS; i++) begin
            if (held_flag[i[PIX_AW-1:0]])
              glow_level[i[PIX_AW-1:0]] = LEVEL_MAX;
            else if (glow_level[i[PIX_AW-1:0]] != '0)
              glow_level[i[PIX_AW-1:0]] = ({24'd0, glow_level[i[PIX_AW-1:0]]} > drop) ?
                  glow_level[i[PIX_AW-1:0]] - drop[LEVEL_W-1:0] : '0;
          end
        end
      end
      ACT_READ: begin
        if (c.pixel < 16'(MAX_PIXELS)) begin
          r.level = glow_level[px];
          if (r.level != '0) begin
            r.lit        = 1'b1;
            prod         = base_bright * r.level;
            r.brightness = 8'(prod / 16'd255);
          end
        end
      end
      default: ;  // unknown action leaves everything alone
    endcase
    for (int i = 0; i < MAX_PIXELS; i++)
      if (glow_level[i[PIX_AW-1:0]] != '0 && !held_flag[i[PIX_AW-1:0]])
        r.animating = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    if (bursty && $urandom_range(0, 2) == 0)
      return $urandom_range(1, 5);
    return 0;
  endfunction

  task automatic push_cmd(input action_t a, input logic [15:0] px, input logic pr,
                          input logic [TIME_W-1:0] now);
    cmd_beat_t c;
    c = '{kind: BEAT_CMD, action: a, pixel: px, pressed: pr, now_ms: now,
          cfg_idx: '0, cfg_data: '0, gap: pick_gap()};
    cmd_q.push_back(c);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] data);
    cmd_beat_t c;
    c = '{kind: BEAT_CFG, action: ACT_NONE, pixel: '0, pressed: 1'b0, now_ms: '0,
          cfg_idx: idx, cfg_data: data, gap: 0};
    cmd_q.push_back(c);
  endtask

  // Mostly a small cluster of pixels, so presses, fades and reads meet.
  function automatic logic [15:0] hot_pixel();
    if ($urandom_range(0, 9) < 7)
      return 16'($urandom_range(0, 15));
    return 16'($urandom_range(0, MAX_PIXELS - 1));
  endfunction

  task automatic push_random_cmd();
    int unsigned       sel;
    int unsigned       tsel;
    logic [TIME_W-1:0] junk_ms;
    sel     = $urandom_range(0, 99);
    junk_ms = $urandom;
    if (sel < 45) begin
      push_cmd(ACT_READ, hot_pixel(), 1'($urandom), junk_ms);
    end else if (sel < 75) begin
      push_cmd(ACT_KEY, hot_pixel(), 1'($urandom), junk_ms);
    end else if (sel < 93) begin
      // Advance time in small steps; now and then hold it, step back or leap.
      tsel = $urandom_range(0, 99);
      if (tsel < 80)
        sim_ms = sim_ms + $urandom_range(1, 80);
      else if (tsel < 88)
        sim_ms = sim_ms;
      else if (tsel < 94)
        sim_ms = sim_ms - $urandom_range(1, 200);
      else
        sim_ms = $urandom;
      push_cmd(ACT_TICK, 16'($urandom), 1'($urandom), sim_ms);
    end else if (sel < 97) begin
      push_cmd(ACT_NONE, 16'($urandom), 1'($urandom), junk_ms);
    end else begin
      push_cmd(($urandom_range(0, 1) == 0) ? ACT_KEY : ACT_READ,
               16'($urandom_range(MAX_PIXELS, 16'hFFFF)), 1'($urandom), junk_ms);
    end
  endtask

  task automatic note_mismatch(input string what);
    n_errors++;
    $display("%0t ERROR: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one beat at a time from cmd_q. Register writes wait until every
  // predicted result is back and the core has sat idle for a few cycles.
  // Each driven signal gets a single nonblocking update per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    cmd_beat_t nxt;
    logic      nxt_start;
    logic      nxt_we;
    nxt_start = start;
    nxt_we    = 1'b0;
    if (rst_n) begin
      if (out_valid)
        results_seen++;
      // Beat taken: predict it now, against the state it will see.
      if (start && !busy) begin
        glow_result_q.push_back(glow_step(cur_cmd));
        act_count[cur_cmd.action]++;
        beats_taken++;
        nxt_start = 1'b0;
      end
      if (beats_taken == results_seen && !nxt_start && !busy)
        settle_cnt++;
      else
        settle_cnt = 0;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0) begin
          if (cmd_q[0].kind == BEAT_CFG) begin
            // Hold the write until the core is drained and quiet.
            if (settle_cnt >= SETTLE_CYC) begin
              nxt = cmd_q.pop_front();
              nxt_we    = 1'b1;
              cfg_index <= nxt.cfg_idx;
              cfg_wdata <= nxt.cfg_data;
              if (nxt.cfg_idx == CFG_FADE_MS)
                fade_ms = nxt.cfg_data[REL_W-1:0];
              else
                base_bright = nxt.cfg_data[LEVEL_W-1:0];
              cfg_writes++;
              settle_cnt = 0;
            end
          end else begin
            nxt = cmd_q.pop_front();
            cur_cmd    = nxt;
            in_action  <= nxt.action;
            in_pixel   <= nxt.pixel;
            in_pressed <= nxt.pressed;
            in_now_ms  <= nxt.now_ms;
            gap_left   = nxt.gap;
            nxt_start  = 1'b1;
          end
        end
      end
    end
    start  <= nxt_start;
    cfg_we <= nxt_we;
  end

  // ---------------------------------------------------------------------------
  // Monitor: results cannot be stalled, so sample every strobe and compare
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_proc
    glow_res_t want;
    if (rst_n && out_valid) begin
      if (glow_result_q.size() == 0) begin
        note_mismatch($sformatf("result beat with nothing expected (lit=%0d level=%0d)",
                                out_lit, out_level));
      end else begin
        want = glow_result_q.pop_front();
        n_checked++;
        if (out_lit !== want.lit)
          note_mismatch($sformatf("beat %0d lit: got %0d want %0d",
                                  n_checked, out_lit, want.lit));
        if (out_level !== want.level)
          note_mismatch($sformatf("beat %0d level: got %0d want %0d",
                                  n_checked, out_level, want.level));
        if (out_brightness !== want.brightness)
          note_mismatch($sformatf("beat %0d brightness: got %0d want %0d",
                                  n_checked, out_brightness, want.brightness));
        if (out_animating !== want.animating)
          note_mismatch($sformatf("beat %0d animating: got %0d want %0d",
                                  n_checked, out_animating, want.animating));
        if (want.lit)
          n_lit++;
        if (want.animating)
          n_fading++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed beats, then randomized phases, each under its
  // own register setting. Finish once everything has drained.
  // ---------------------------------------------------------------------------
  initial begin : stim_proc
    logic [REL_W-1:0]   phase_rel  [7];
    logic [LEVEL_W-1:0] phase_base [7];
    int unsigned        total_phase;
    int unsigned        done_beats;

    for (int i = 0; i < MAX_PIXELS; i++) begin
      held_flag[i[PIX_AW-1:0]]  = 1'b0;
      glow_level[i[PIX_AW-1:0]] = '0;
    end
    last_tick_ms = '0;
    fade_ms      = RELEASE_RST;
    base_bright  = BASE_RST;

    // Directed: reset settings first, then instant fade with zero brightness.
    push_cmd(ACT_READ, 16'd0, 1'b0, '0);                    // dark after reset
    push_cmd(ACT_KEY, 16'd0, 1'b1, '0);
    push_cmd(ACT_READ, 16'd0, 1'b0, '0);                    // full level
    push_cmd(ACT_KEY, 16'(MAX_PIXELS - 1), 1'b1, '0);       // top pixel held
    push_cmd(ACT_KEY, 16'd0, 1'b0, '0);                     // release -> fading
    push_cmd(ACT_TICK, 16'd0, 1'b0, 32'd100);
    push_cmd(ACT_READ, 16'd0, 1'b1, 32'hFFFF_FFFF);
    push_cmd(ACT_KEY, 16'(MAX_PIXELS), 1'b1, '0);           // just out of range
    push_cmd(ACT_KEY, 16'hFFFF, 1'b0, '0);
    push_cmd(ACT_READ, 16'hFFFF, 1'b1, '0);                 // out-of-range read
    push_cmd(ACT_TICK, 16'd0, 1'b0, 32'd100);               // time stands still
    push_cmd(ACT_TICK, 16'd0, 1'b0, 32'd50);                // time goes backwards
    push_cmd(ACT_NONE, 16'd0, 1'b1, 32'hFFFF_FFFF);         // unknown action
    push_cmd(ACT_TICK, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);      // product wraps
    push_cmd(ACT_READ, 16'd0, 1'b0, '0);
    push_cmd(ACT_KEY, 16'(MAX_PIXELS - 1), 1'b0, '0);
    push_cmd(ACT_TICK, 16'd0, 1'b0, 32'd0);                 // back to zero
    push_cmd(ACT_READ, 16'(MAX_PIXELS - 1), 1'b0, '0);
    push_cfg(CFG_FADE_MS, 16'd0);
    push_cfg(CFG_BASE_BRIGHT, 16'hFF00);                    // upper byte ignored
    push_cmd(ACT_KEY, 16'd5, 1'b1, '0);
    push_cmd(ACT_KEY, 16'd5, 1'b0, '0);
    push_cmd(ACT_READ, 16'd5, 1'b0, '0);                    // lit but zero brightness
    push_cmd(ACT_TICK, 16'd0, 1'b0, 32'd10);                // zero fade time: dark
    push_cmd(ACT_READ, 16'd5, 1'b0, '0);
    sim_ms = 32'd10;

    // Random phases; the first two and the fourth pin the fade-time extremes.
    phase_rel  = '{16'hFFFF, 16'd1, 16'($urandom_range(100, 2000)), 16'd0,
                   16'($urandom_range(50, 800)), 16'($urandom), RELEASE_RST};
    phase_base = '{8'd255, 8'd128, 8'($urandom), 8'd200, 8'd1, 8'($urandom), BASE_RST};
    total_phase = $size(phase_rel);
    done_beats  = 0;
    for (int ph = 0; ph < total_phase; ph++) begin
      push_cfg(CFG_FADE_MS, phase_rel[ph]);
      push_cfg(CFG_BASE_BRIGHT, {8'($urandom), phase_base[ph]});
      for (int k = 0; k < PHASE_BEATS; k++) begin
        // Alternate bursty and gap-free stretches; the tail runs flat out.
        bursty = (done_beats < (total_phase - 1) * PHASE_BEATS) &&
                 ((done_beats / 40) % 3 != 2);
        push_random_cmd();
        done_beats++;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || start || glow_result_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    $display("Covered %0d beats: %0d key, %0d tick, %0d read, %0d unknown; %0d reg writes.",
             beats_taken, act_count[ACT_KEY], act_count[ACT_TICK],
             act_count[ACT_READ], act_count[ACT_NONE], cfg_writes);
    $display("Checked %0d results: %0d lit reads, %0d with a pixel still fading.",
             n_checked, n_lit, n_fading);
    if (n_errors == 0)
      $display("** held_key_glow_envelope_core: PASSED **");
    else
      $display("** held_key_glow_envelope_core: FAILED **");
    $finish;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin : watchdog_proc
    #(WATCHDOG_NS);
    $display("Timeout with %0d results still outstanding.", glow_result_q.size());
    $display("** held_key_glow_envelope_core: FAILED **");
    $finish;
  end

endmodule
